>>> src/hpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_pkg: shared types, constants and helpers
// Calibration layout, pipeline depth figures and fixed-point helper functions
// used by the compensation pipeline.
// ----------------------------------------------------------------------------
package hpt_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_CAL = 3'd0,
		REG_PRESS_A  = 3'd1,
		REG_PRESS_B  = 3'd2,
		REG_PRESS_C  = 3'd3,
		REG_HUM_CAL  = 3'd4
	} cfg_reg_t;

	// pressure calibration bundle
	typedef struct packed {
		logic [63:0] a;   // P1 u16, P2..P4 s16
		logic [63:0] b;   // P5..P8 s16
		logic [15:0] c;   // P9 s16
	} press_cal_t;

	// divider: two quotient bits per stage
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = 64 / DIV_BITS;
	localparam int DIV_LAT    = DIV_STAGES + 2;
	localparam int DEN_W      = 31;

	// stage where the divider is fed, and total depth
	localparam int DIV_IN_STAGE = 13;
	localparam int N_STAGES     = DIV_IN_STAGE + DIV_LAT + 6;
	localparam int INV_DLY      = N_STAGES - DIV_IN_STAGE;
	localparam int TC_STAGE     = 5;
	localparam int HUM_STAGE    = 15;

	// formula constants
	localparam logic [63:0] P_TFINE_OFS = 64'd128000;
	localparam logic [20:0] P_FULL      = 21'd1048576;
	localparam logic [63:0] P_SCALE     = 64'd3125;
	localparam logic [63:0] P_BIAS47    = 64'd1 << 47;
	localparam logic [31:0] H_TFINE_OFS = 32'd76800;
	localparam logic [31:0] H_RND14     = 32'd16384;
	localparam logic [31:0] H_ONE15     = 32'd32768;
	localparam logic [31:0] H_MID_OFS   = 32'd2097152;
	localparam logic [31:0] H_RND13     = 32'd8192;
	localparam logic [31:0] H_CLAMP     = 32'd419430400;
	localparam logic [16:0] HUM_MAX     = 17'd102400;
	localparam logic [31:0] T_RND       = 32'd128;
	localparam logic [31:0] T_MUL       = 32'd5;

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		asr32 = $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
		asr64 = $signed(x) >>> n;
	endfunction

	function automatic logic [31:0] sx8_32(input logic [7:0] x);
		sx8_32 = {{24{x[7]}}, x};
	endfunction

	function automatic logic [31:0] sx12_32(input logic [11:0] x);
		sx12_32 = {{20{x[11]}}, x};
	endfunction

	function automatic logic [31:0] sx16_32(input logic [15:0] x);
		sx16_32 = {{16{x[15]}}, x};
	endfunction

	function automatic logic [63:0] sx16_64(input logic [15:0] x);
		sx16_64 = {{48{x[15]}}, x};
	endfunction

	function automatic logic [63:0] sx32_64(input logic [31:0] x);
		sx32_64 = {{32{x[31]}}, x};
	endfunction

endpackage
`default_nettype wire

>>> src/hpt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_if: reading and result channels
// Valid/ready channels carrying one raw reading triple or one result.
// ----------------------------------------------------------------------------
interface hpt_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_temperature;
	logic [19:0] raw_pressure;
	logic [15:0] raw_humidity;

	modport source (output valid, raw_temperature, raw_pressure, raw_humidity,
		input ready);
	modport sink (input valid, raw_temperature, raw_pressure, raw_humidity,
		output ready);
endinterface

interface hpt_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] temperature_centi;
	logic        [31:0] pressure_q24_8;
	logic               pressure_invalid;
	logic        [16:0] humidity_q22_10;

	modport source (output valid, temperature_centi, pressure_q24_8, pressure_invalid,
		humidity_q22_10, input ready);
	modport sink (input valid, temperature_centi, pressure_q24_8, pressure_invalid,
		humidity_q22_10, output ready);
endinterface
`default_nettype wire

>>> src/humidity_pressure_temp_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_pressure_temp_compensation: integer sensor compensation
// Turns one raw temperature/pressure/humidity triple into compensated values.
//
// Usage:
//  - sample carries a raw reading triple, result the compensated beat:
//    temperature in 0.01 C, pressure in Q24.8 Pa with a zero-divisor flag,
//    humidity in Q22.10 percent. A beat moves when valid and ready are high.
//  - Calibration words are written through wr_en/wr_index/wr_data while no
//    reading is in flight; unknown indexes are ignored.
//  - 53 register stages; one beat is taken every cycle while result is not
//    stalled. Depth is set by the pressure path, mostly the pipelined divider
//    at two quotient bits per stage.
//  - When result is stalled the whole pipeline holds and sample.ready drops;
//    nothing is lost or repeated. sample.ready follows result.ready while result.valid is high.
//  - Reset clears the calibration registers and all stage valid bits.
// ----------------------------------------------------------------------------
module humidity_pressure_temp_compensation import hpt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	hpt_in_if.sink                sample,
	hpt_out_if.source             result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	logic [47:0]       temp_cal_q;
	press_cal_t        press_cal_q;
	logic [63:0]       hum_cal_q;
	logic              en;
	logic [N_STAGES:1] v_q;

	logic [19:0] raw_t_s1;
	logic [19:0] rawp_q [1:4];
	logic [15:0] rawh_q [1:4];
	logic [31:0] t1, t2, t3;
	logic [31:0] aprod_s2, dsq_s2, a_s3, bprod_s3, tfine_s4;
	logic [31:0] tc_q [TC_STAGE:N_STAGES];
	logic [16:0] hum_s15;
	logic [16:0] hum_q [HUM_STAGE+1:N_STAGES];
	logic [31:0] pres_out;
	logic        inv_out;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q  <= '0;
			press_cal_q <= '0;
			hum_cal_q   <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_TEMP_CAL: temp_cal_q    <= wr_data[47:0];
				REG_PRESS_A:  press_cal_q.a <= wr_data;
				REG_PRESS_B:  press_cal_q.b <= wr_data;
				REG_PRESS_C:  press_cal_q.c <= wr_data[15:0];
				REG_HUM_CAL:  hum_cal_q     <= wr_data;
				default: ;
			endcase
		end
	end

	// pipeline advance and valid chain
	assign en           = !result.valid || result.ready;
	assign sample.ready = en;
	assign result.valid = v_q[N_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[N_STAGES-1:1], sample.valid};
		end
	end

	// input capture and raw delays
	always_ff @(posedge clk) begin
		if (en) begin
			raw_t_s1  <= sample.raw_temperature;
			rawp_q[1] <= sample.raw_pressure;
			rawh_q[1] <= sample.raw_humidity;
			for (int i = 2; i <= 4; i++) begin
				rawp_q[i] <= rawp_q[i-1];
				rawh_q[i] <= rawh_q[i-1];
			end
		end
	end

	// temperature coefficients
	assign t1 = {16'b0, temp_cal_q[15:0]};
	assign t2 = sx16_32(temp_cal_q[31:16]);
	assign t3 = sx16_32(temp_cal_q[47:32]);

	// fine temperature and hundredths of a degree
	always_ff @(posedge clk) begin
		if (en) begin
			aprod_s2 <= ({15'b0, raw_t_s1[19:3]} - {15'b0, temp_cal_q[15:0], 1'b0}) * t2;
			dsq_s2   <= ({16'b0, raw_t_s1[19:4]} - t1) * ({16'b0, raw_t_s1[19:4]} - t1);
			a_s3     <= asr32(aprod_s2, 11);
			bprod_s3 <= asr32(dsq_s2, 12) * t3;
			tfine_s4 <= a_s3 + asr32(bprod_s3, 14);
			tc_q[TC_STAGE] <= asr32(tfine_s4 * T_MUL + T_RND, 8);
			for (int i = TC_STAGE + 1; i <= N_STAGES; i++) begin
				tc_q[i] <= tc_q[i-1];
			end
		end
	end

	hpt_hum u_hum (
		.clk, .en,
		.tfine(tfine_s4), .raw_humidity(rawh_q[4]), .cal(hum_cal_q),
		.hum(hum_s15)
	);

	hpt_press u_press (
		.clk, .en,
		.tfine(tfine_s4), .raw_pressure(rawp_q[4]), .cal(press_cal_q),
		.pres(pres_out), .invalid(inv_out)
	);

	// align humidity with the pressure path
	always_ff @(posedge clk) begin
		if (en) begin
			hum_q[HUM_STAGE+1] <= hum_s15;
			for (int i = HUM_STAGE + 2; i <= N_STAGES; i++) begin
				hum_q[i] <= hum_q[i-1];
			end
		end
	end

	assign result.temperature_centi = tc_q[N_STAGES];
	assign result.pressure_q24_8    = pres_out;
	assign result.pressure_invalid  = inv_out;
	assign result.humidity_q22_10   = hum_q[N_STAGES];

	// checks
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.pressure_invalid |-> result.pressure_q24_8 == '0)
		else $error("invalid pressure beat carries nonzero value");

	a_hum_max: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.humidity_q22_10 <= HUM_MAX)
		else $error("humidity beyond clamp");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> v_q == $past(v_q))
		else $error("pipeline moved while output stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> v_q[1])
		else $error("accepted beat did not enter first stage");

endmodule
`default_nettype wire

>>> src/hpt_mul64.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_mul64: two-stage 64x64 multiply, low 64 bits
// Three 32x32 partial products in the first stage, summed in the second.
// ----------------------------------------------------------------------------
module hpt_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] ll_s1;
	logic [31:0] hl_s1;
	logic [31:0] lh_s1;

	// partial products; high x high falls off the top
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			hl_s1 <= a[63:32] * b[31:0];
			lh_s1 <= a[31:0] * b[63:32];
		end
	end

	// recombine
	always_ff @(posedge clk) begin
		if (en) begin
			p <= ll_s1 + {hl_s1 + lh_s1, 32'b0};
		end
	end

endmodule
`default_nettype wire

>>> src/hpt_sdiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_sdiv: pipelined signed 64 / 31-bit divide
// Restoring divide on magnitudes, DIV_BITS quotient bits per stage, truncating
// toward zero; the quotient wraps modulo 2^64.
// ----------------------------------------------------------------------------
module hpt_sdiv import hpt_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [63:0]      num,
	input  logic [DEN_W-1:0] den,
	output logic [63:0]      quo
);

	logic [63:0]      dq_q  [0:DIV_STAGES];
	logic [DEN_W-1:0] rem_q [0:DIV_STAGES];
	logic [DEN_W-1:0] ad_q  [0:DIV_STAGES];
	logic             neg_q [0:DIV_STAGES];

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		if (en) begin
			dq_q[0]  <= num[63] ? (64'd0 - num) : num;
			ad_q[0]  <= den[DEN_W-1] ? (DEN_W'(0) - den) : den;
			rem_q[0] <= '0;
			neg_q[0] <= num[63] ^ den[DEN_W-1];
		end
	end

	// shift-subtract stages
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_step
		logic [63:0]      dq_n;
		logic [DEN_W-1:0] rem_n;

		always_comb begin
			logic [DEN_W:0] r2;
			dq_n  = dq_q[k-1];
			rem_n = rem_q[k-1];
			for (int j = 0; j < DIV_BITS; j++) begin
				r2   = {rem_n, dq_n[63]};
				dq_n = {dq_n[62:0], 1'b0};
				if (r2 >= {1'b0, ad_q[k-1]}) begin
					rem_n   = DEN_W'(r2 - {1'b0, ad_q[k-1]});
					dq_n[0] = 1'b1;
				end else begin
					rem_n = r2[DEN_W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dq_q[k]  <= dq_n;
				rem_q[k] <= rem_n;
				ad_q[k]  <= ad_q[k-1];
				neg_q[k] <= neg_q[k-1];
			end
		end
	end

	// apply sign
	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_q[DIV_STAGES] ? (64'd0 - dq_q[DIV_STAGES]) : dq_q[DIV_STAGES];
		end
	end

endmodule
`default_nettype wire

>>> src/hpt_hum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_hum: humidity compensation pipeline
// 32-bit wrapping arithmetic from fine temperature (stage 4) to clamped
// Q22.10 humidity (stage 15).
// ----------------------------------------------------------------------------
module hpt_hum import hpt_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] tfine,
	input  logic [15:0] raw_humidity,
	input  logic [63:0] cal,
	output logic [16:0] hum
);

	logic [31:0] h1, h2, h3, h4, h5, h6;
	logic [31:0] x_s5, h5x_s6, xh6_s6, xh3_s6;
	logic [15:0] adch_s5, adch_s6;
	logic [31:0] left_s7, am_s7, bm_s7;
	logic [31:0] mprod_s8, left_s8;
	logic [31:0] mid_s9, left_s9;
	logic [31:0] rprod_s10, left_s10;
	logic [31:0] right_s11, left_s11;
	logic [31:0] xx_s12;
	logic [31:0] sq_s13, xx_s13;
	logic [31:0] t_s14, xx_s14;
	logic [31:0] xf;

	// coefficient fields
	assign h1 = {24'b0, cal[7:0]};
	assign h2 = sx16_32(cal[23:8]);
	assign h3 = {24'b0, cal[31:24]};
	assign h4 = sx12_32(cal[43:32]);
	assign h5 = sx12_32(cal[55:44]);
	assign h6 = sx8_32(cal[63:56]);

	// offset and first products
	always_ff @(posedge clk) begin
		if (en) begin
			x_s5    <= tfine - H_TFINE_OFS;
			adch_s5 <= raw_humidity;
			h5x_s6  <= h5 * x_s5;
			xh6_s6  <= x_s5 * h6;
			xh3_s6  <= x_s5 * h3;
			adch_s6 <= adch_s5;
		end
	end

	// left term and middle factors
	always_ff @(posedge clk) begin
		if (en) begin
			left_s7 <= asr32({2'b0, adch_s6, 14'b0} - (h4 << 20) - h5x_s6 + H_RND14, 15);
			am_s7   <= asr32(xh6_s6, 10);
			bm_s7   <= asr32(xh3_s6, 11) + H_ONE15;
		end
	end

	// right term
	always_ff @(posedge clk) begin
		if (en) begin
			mprod_s8  <= am_s7 * bm_s7;
			left_s8   <= left_s7;
			mid_s9    <= asr32(mprod_s8, 10) + H_MID_OFS;
			left_s9   <= left_s8;
			rprod_s10 <= mid_s9 * h2;
			left_s10  <= left_s9;
			right_s11 <= asr32(rprod_s10 + H_RND13, 14);
			left_s11  <= left_s10;
		end
	end

	// product and square correction
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s12 <= left_s11 * right_s11;
			sq_s13 <= asr32(xx_s12, 15) * asr32(xx_s12, 15);
			xx_s13 <= xx_s12;
			t_s14  <= asr32(sq_s13, 7) * h1;
			xx_s14 <= xx_s13;
		end
	end

	// clamp to 0..100 percent
	assign xf = xx_s14 - asr32(t_s14, 4);

	always_ff @(posedge clk) begin
		if (en) begin
			if (xf[31]) begin
				hum <= '0;
			end else if (xf > H_CLAMP) begin
				hum <= HUM_MAX;
			end else begin
				hum <= xf[28:12];
			end
		end
	end

endmodule
`default_nettype wire

>>> src/hpt_press.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_press: pressure compensation pipeline
// 64-bit wrapping arithmetic from fine temperature (stage 4) through the
// pipelined divider to Q24.8 pressure and the zero-divisor flag.
// ----------------------------------------------------------------------------
module hpt_press import hpt_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] tfine,
	input  logic [19:0] raw_pressure,
	input  press_cal_t  cal,
	output logic [31:0] pres,
	output logic        invalid
);

	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [63:0] v1_s5;
	logic [20:0] pr_q [5:10];
	logic [63:0] sq_s7, m5_s7, m2_s7, m5_s8, m2_s8, m5_s9, m2_s9;
	logic [63:0] v2a_s9, v1a_s9;
	logic [63:0] v2_s10, v1b_s10;
	logic [63:0] nump_s11;
	logic [63:0] prod_s12;
	logic [63:0] num_s13;
	logic [DEN_W-1:0] den_s13;
	logic        inv_q [0:INV_DLY-1];
	logic [63:0] q_s47, q_s48, q_s49, q_s50, q_s51;
	logic [63:0] ps_s49, p8q_s49, v2p_s50, v2p_s51, pss_s51;
	logic [63:0] tsum_s52;

	// coefficient fields
	assign p1 = {48'b0, cal.a[15:0]};
	assign p2 = sx16_64(cal.a[31:16]);
	assign p3 = sx16_64(cal.a[47:32]);
	assign p4 = sx16_64(cal.a[63:48]);
	assign p5 = sx16_64(cal.b[15:0]);
	assign p6 = sx16_64(cal.b[31:16]);
	assign p7 = sx16_64(cal.b[47:32]);
	assign p8 = sx16_64(cal.b[63:48]);
	assign p9 = sx16_64(cal.c);

	// offset fine temperature; inverted reading
	always_ff @(posedge clk) begin
		if (en) begin
			v1_s5    <= sx32_64(tfine) - P_TFINE_OFS;
			pr_q[5]  <= P_FULL - {1'b0, raw_pressure};
			for (int i = 6; i <= 10; i++) begin
				pr_q[i] <= pr_q[i-1];
			end
		end
	end

	// first products
	hpt_mul64 u_mul_sq (.clk, .en, .a(v1_s5), .b(v1_s5), .p(sq_s7));
	hpt_mul64 u_mul_m5 (.clk, .en, .a(v1_s5), .b(p5),    .p(m5_s7));
	hpt_mul64 u_mul_m2 (.clk, .en, .a(v1_s5), .b(p2),    .p(m2_s7));

	// square times P6 and P3
	hpt_mul64 u_mul_v2a (.clk, .en, .a(sq_s7), .b(p6), .p(v2a_s9));
	hpt_mul64 u_mul_v1a (.clk, .en, .a(sq_s7), .b(p3), .p(v1a_s9));

	always_ff @(posedge clk) begin
		if (en) begin
			m5_s8 <= m5_s7;
			m2_s8 <= m2_s7;
			m5_s9 <= m5_s8;
			m2_s9 <= m2_s8;
		end
	end

	// sum terms
	always_ff @(posedge clk) begin
		if (en) begin
			v2_s10   <= v2a_s9 + (m5_s9 << 17) + (p4 << 35);
			v1b_s10  <= asr64(v1a_s9, 8) + (m2_s9 << 12) + P_BIAS47;
			nump_s11 <= {12'b0, pr_q[10], 31'b0} - v2_s10;
		end
	end

	// divisor and dividend
	hpt_mul64 u_mul_den (.clk, .en, .a(v1b_s10),  .b(p1),      .p(prod_s12));
	hpt_mul64 u_mul_num (.clk, .en, .a(nump_s11), .b(P_SCALE), .p(num_s13));

	always_ff @(posedge clk) begin
		if (en) begin
			den_s13  <= prod_s12[63:33];
			inv_q[0] <= prod_s12[63:33] == '0;
			for (int i = 1; i < INV_DLY; i++) begin
				inv_q[i] <= inv_q[i-1];
			end
		end
	end

	hpt_sdiv u_div (.clk, .en, .num(num_s13), .den(den_s13), .quo(q_s47));

	// post-divide corrections
	hpt_mul64 u_mul_ps  (.clk, .en, .a(p9), .b(asr64(q_s47, 13)), .p(ps_s49));
	hpt_mul64 u_mul_p8q (.clk, .en, .a(p8), .b(q_s47),            .p(p8q_s49));
	hpt_mul64 u_mul_pss (.clk, .en, .a(ps_s49), .b(asr64(q_s49, 13)), .p(pss_s51));

	always_ff @(posedge clk) begin
		if (en) begin
			q_s48    <= q_s47;
			q_s49    <= q_s48;
			q_s50    <= q_s49;
			q_s51    <= q_s50;
			v2p_s50  <= asr64(p8q_s49, 19);
			v2p_s51  <= v2p_s50;
			tsum_s52 <= q_s51 + asr64(pss_s51, 25) + v2p_s51;
		end
	end

	// final scale and zero-divisor override
	always_ff @(posedge clk) begin
		if (en) begin
			pres    <= inv_q[INV_DLY-1] ? '0 : 32'(asr64(tsum_s52, 8) + (p7 << 4));
			invalid <= inv_q[INV_DLY-1];
		end
	end

endmodule
`default_nettype wire

>>> test/tb_humidity_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_humidity_pressure_temp_compensation: compensation pipeline testbench
// Feeds raw reading triples under several calibration sets and handshake
// stall patterns, predicts each compensated beat in integer arithmetic and
// compares every result beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_humidity_pressure_temp_compensation;
	import hpt_pkg::*;

	localparam int          WATCHDOG_LIMIT = 20000;
	localparam int          SETTLE_CYCLES  = 60;
	localparam logic [2:0]  REG_SPARE      = 3'd5;

	typedef struct {
		logic [31:0] temperature_centi;
		logic [31:0] pressure_q24_8;
		logic        pressure_invalid;
		logic [16:0] humidity_q22_10;
	} compensated_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	hpt_in_if  sample();
	hpt_out_if result();

	humidity_pressure_temp_compensation u_top (
		.clk(clk), .arst_n(arst_n), .sample(sample.sink), .result(result.source),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// shadow calibration
	logic [47:0] cal_temp;
	logic [63:0] cal_press_a, cal_press_b, cal_hum;
	logic [15:0] cal_press_c;

	compensated_t expected_q[$];
	int tx_idle_pct, rx_idle_pct;
	int errors = 0;
	int readings_sent = 0, results_seen = 0, invalid_seen = 0;
	int stall_cnt = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
		sra32 = $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
		sra64 = $signed(x) >>> n;
	endfunction

	function automatic compensated_t compensate(input logic [19:0] adc_t,
		input logic [19:0] adc_p, input logic [15:0] adc_h);
		compensated_t r;
		logic [31:0] t1, t2, t3, ta, td, tb, tfine, x, left, mid, right, hsq;
		logic [31:0] h1, h2, h3, h4, h5, h6, at, ah;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, s, num, an, ad, q;
		// temperature, 32-bit wrap
		at = {12'd0, adc_t};
		t1 = {16'd0, cal_temp[15:0]};
		t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
		t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
		ta = ((at >> 3) - (t1 << 1)) * t2;
		ta = sra32(ta, 11);
		td = (at >> 4) - t1;
		tb = td * td;
		tb = sra32(tb, 12) * t3;
		tb = sra32(tb, 14);
		tfine = ta + tb;
		r.temperature_centi = sra32(tfine * 32'd5 + 32'd128, 8);
		// pressure, 64-bit wrap
		p1 = {48'd0, cal_press_a[15:0]};
		p2 = {{48{cal_press_a[31]}}, cal_press_a[31:16]};
		p3 = {{48{cal_press_a[47]}}, cal_press_a[47:32]};
		p4 = {{48{cal_press_a[63]}}, cal_press_a[63:48]};
		p5 = {{48{cal_press_b[15]}}, cal_press_b[15:0]};
		p6 = {{48{cal_press_b[31]}}, cal_press_b[31:16]};
		p7 = {{48{cal_press_b[47]}}, cal_press_b[47:32]};
		p8 = {{48{cal_press_b[63]}}, cal_press_b[63:48]};
		p9 = {{48{cal_press_c[15]}}, cal_press_c};
		v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
		r.pressure_q24_8 = '0;
		r.pressure_invalid = (v1 == 64'd0);
		if (!r.pressure_invalid) begin
			p = 64'd1048576 - {44'd0, adc_p};
			num = ((p << 31) - v2) * 64'd3125;
			// truncating signed divide, most negative / -1 wraps
			an = num[63] ? -num : num;
			ad = v1[63] ? -v1 : v1;
			q = an / ad;
			p = (num[63] != v1[63]) ? -q : q;
			s = sra64(p, 13);
			v1 = sra64(p9 * s * s, 25);
			v2 = sra64(p8 * p, 19);
			p = sra64(p + v1 + v2, 8) + (p7 << 4);
			r.pressure_q24_8 = p[31:0];
		end
		// humidity, 32-bit wrap
		ah = {16'd0, adc_h};
		h1 = {24'd0, cal_hum[7:0]};
		h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
		h3 = {24'd0, cal_hum[31:24]};
		h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
		h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
		h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};
		x = tfine - 32'd76800;
		left = sra32((ah << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
		mid = sra32(x * h3, 11) + 32'd32768;
		mid = sra32(sra32(x * h6, 10) * mid, 10) + 32'd2097152;
		right = sra32(mid * h2 + 32'd8192, 14);
		x = left * right;
		hsq = sra32(x, 15);
		x = x - sra32(sra32(hsq * hsq, 7) * h1, 4);
		if (x[31])
			x = '0;
		else if (x > 32'd419430400)
			x = 32'd419430400;
		r.humidity_q22_10 = x[28:12];
		return r;
	endfunction

	// receiver stalls
	always @(negedge clk) begin
		result.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		compensated_t e;
		if (arst_n && result.valid && result.ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("result beat with no reading outstanding");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (result.temperature_centi !== e.temperature_centi) begin
					$error("temperature_centi: expected %0d, got %0d",
						$signed(e.temperature_centi), result.temperature_centi);
					errors++;
				end
				if (result.pressure_q24_8 !== e.pressure_q24_8) begin
					$error("pressure_q24_8: expected %0d, got %0d",
						e.pressure_q24_8, result.pressure_q24_8);
					errors++;
				end
				if (result.pressure_invalid !== e.pressure_invalid) begin
					$error("pressure_invalid: expected %0b, got %0b",
						e.pressure_invalid, result.pressure_invalid);
					errors++;
				end
				if (result.humidity_q22_10 !== e.humidity_q22_10) begin
					$error("humidity_q22_10: expected %0d, got %0d",
						e.humidity_q22_10, result.humidity_q22_10);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready))
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_reading(input logic [19:0] t, input logic [19:0] p,
		input logic [15:0] h);
		compensated_t e;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			sample.valid <= 1'b0;
			@(negedge clk);
		end
		sample.valid <= 1'b1;
		sample.raw_temperature <= t;
		sample.raw_pressure <= p;
		sample.raw_humidity <= h;
		e = compensate(t, p, h);
		do @(posedge clk); while (!sample.ready);
		expected_q.push_back(e);
		readings_sent++;
		if (e.pressure_invalid)
			invalid_seen++;
		@(negedge clk);
	endtask

	// drops valid and waits until the pipeline is empty
	task automatic drain;
		sample.valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_TEMP_CAL: cal_temp = data[47:0];
			REG_PRESS_A:  cal_press_a = data;
			REG_PRESS_B:  cal_press_b = data;
			REG_PRESS_C:  cal_press_c = data[15:0];
			REG_HUM_CAL:  cal_hum = data;
			default: ;
		endcase
	endtask

	task automatic load_typical;
		write_reg(REG_TEMP_CAL, {16'(-16'sd1000), 16'd26435, 16'd27504});
		write_reg(REG_PRESS_A, {16'd2855, 16'd3024, 16'(-16'sd10685), 16'd36477});
		write_reg(REG_PRESS_B, {16'(-16'sd14600), 16'd15500, 16'(-16'sd7), 16'd140});
		write_reg(REG_PRESS_C, 64'd6000);
		write_reg(REG_HUM_CAL, {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
	endtask

	// calibration near a real part, or fully random now and then
	task automatic load_random_cal;
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_TEMP_CAL, {$urandom, $urandom});
			write_reg(REG_PRESS_A, {$urandom, $urandom});
			write_reg(REG_PRESS_B, {$urandom, $urandom});
			write_reg(REG_PRESS_C, {$urandom, $urandom});
			write_reg(REG_HUM_CAL, {$urandom, $urandom});
		end else begin
			load_typical();
			write_reg(REG_TEMP_CAL, {cal_temp[47:40], 8'($urandom), cal_temp[31:24],
				8'($urandom), cal_temp[15:8], 8'($urandom)});
			write_reg(REG_PRESS_A, cal_press_a ^ 64'({$urandom} & 32'h00FF_00FF)
				^ ({32'($urandom & 32'h00FF_00FF)} << 32));
			write_reg(REG_PRESS_B, cal_press_b ^ {16'($urandom_range(0, 255)),
				16'($urandom_range(0, 255)), 16'($urandom_range(0, 3)),
				16'($urandom_range(0, 255))});
			write_reg(REG_PRESS_C, cal_press_c ^ 16'($urandom_range(0, 255)));
			write_reg(REG_HUM_CAL, cal_hum ^ {8'($urandom_range(0, 63)),
				24'($urandom & 32'h0FF_0FF), 8'($urandom), 16'($urandom_range(0, 255)),
				8'($urandom)});
		end
	endtask

	task automatic test_directed;
		// zero calibration: pressure divisor is zero
		send_reading('0, '0, '0);
		send_reading('1, '1, '1);
		drain();
		load_typical();
		send_reading(20'd519888, 20'd415148, 16'd30000);
		send_reading('0, '0, '0);
		send_reading('1, '1, '1);
		send_reading('0, '1, 16'hFFFF);
		send_reading('1, '0, 16'h0000);
		send_reading(20'h80000, 20'h80000, 16'h8000);
		send_reading(20'd519888, 20'd415148, 16'hFFFF);  // humidity clamps high
		send_reading(20'd519888, 20'd415148, 16'h0000);  // humidity clamps low
		drain();
		// unlisted index must leave calibration alone
		write_reg(REG_SPARE, '1);
		send_reading(20'd520000, 20'd400000, 16'd28000);
		drain();
		// all-ones calibration words
		write_reg(REG_TEMP_CAL, '1);
		write_reg(REG_PRESS_A, '1);
		write_reg(REG_PRESS_B, '1);
		write_reg(REG_PRESS_C, '1);
		write_reg(REG_HUM_CAL, '1);
		send_reading('0, '0, '0);
		send_reading('1, '1, '1);
		send_reading(20'd519888, 20'd415148, 16'd30000);
		drain();
		// divisor forced to zero by P1, temperature and humidity still live
		load_typical();
		write_reg(REG_PRESS_A, cal_press_a & ~64'hFFFF);
		send_reading(20'd519888, 20'd415148, 16'd30000);
		send_reading(20'd300000, 20'd600000, 16'd20000);
		drain();
	endtask

	task automatic test_random(input int tx_pct, input int rx_pct, input int blocks);
		logic [19:0] t, p;
		logic [15:0] h;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int b = 0; b < blocks; b++) begin
			load_random_cal();
			for (int i = 0; i < 26; i++) begin
				if ($urandom_range(0, 2) == 0) begin
					t = 20'($urandom);
					p = 20'($urandom);
					h = 16'($urandom);
				end else begin
					t = 20'($urandom_range(380000, 620000));
					p = 20'($urandom_range(250000, 600000));
					h = 16'($urandom_range(15000, 45000));
				end
				send_reading(t, p, h);
				// hold the sender until the pipeline empties
				if (i == 13 && b == 0) begin
					sample.valid <= 1'b0;
					wait (expected_q.size() == 0);
					@(negedge clk);
				end
			end
			drain();
		end
	endtask

	initial begin
		sample.valid = 1'b0;
		sample.raw_temperature = '0;
		sample.raw_pressure = '0;
		sample.raw_humidity = '0;
		result.ready = 1'b0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		cal_temp = '0;
		cal_press_a = '0;
		cal_press_b = '0;
		cal_press_c = '0;
		cal_hum = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		tx_idle_pct = 11;
		rx_idle_pct = 71;
		test_directed();
		test_random(11, 71, 5);
		test_random(71, 11, 5);
		test_random(0, 0, 5);

		wait (expected_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d readings and %0d result beats (%0d with zero divisor),",
			readings_sent, results_seen, invalid_seen);
		$display("over reset, extreme and random calibration sets and three stall mixes.");
		if (errors == 0 && expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
